// ===== rtl/setg_pkg.sv =====
// ----------------------------------------------------------------------------
// setg_pkg
// Shared types and constants for the edge trigger search block.
// ----------------------------------------------------------------------------
package setg_pkg;

  localparam int LEVEL_BITS = 12;
  localparam int INDEX_BITS = 11;

  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 12'd2048;

  localparam logic FUNC_STORE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

// ===== rtl/setg_store.sv =====
// ----------------------------------------------------------------------------
// setg_store
// Circular sample memory with one write and one registered read port.
// Entries beyond the fill count read as zero, which stands in for the
// cleared contents after reset.
// ----------------------------------------------------------------------------
module setg_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  localparam logic [AW:0] FULL = (AW+1)'(DEPTH);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic          rd_ok_r;
  logic          rd_ok_nxt;
  logic [AW:0]   fill_r;

  // writes land in order from index 0, so written entries are [0, fill)
  assign rd_ok_nxt = (fill_r == FULL) || ({1'b0, rd_addr} < fill_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      rd_ok_r <= rd_ok_nxt;
      if (wr_en && fill_r != FULL) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : '0;

endmodule

// ===== rtl/scope_edge_trigger_search.sv =====
// ----------------------------------------------------------------------------
// scope_edge_trigger_search
// Sample capture into a circular store with a backward edge trigger search.
//
// Input channel (in_valid/in_ready): in_func selects a store (0) or a search
// (1). A store writes in_sample_value after the newest sample and gives no
// output item. A search starts SCREEN_WIDTH/2 positions before the newest
// sample and walks back through 1 to STORE_DEPTH/2 positions, one memory
// read per cycle on the single read port, comparing each sample pair
// against cfg_wr_data's level (rising or falling per in_falling_edge).
// in_ready is low while a search runs.
// Output channel (out_valid/out_ready): out_trigger_index and out_found are
// held in a register until taken; stores are still accepted while it waits,
// a finished search waits in its last state for the register to drain.
// Reset: the level returns to 2048, the store reads as all zero and the
// first sample lands at index 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module scope_edge_trigger_search #(
  parameter int STORE_DEPTH  = 2048,
  parameter int SCREEN_WIDTH = 128,
  parameter int SAMPLE_BITS  = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_func,
  input  logic [SAMPLE_BITS-1:0]         in_sample_value,
  input  logic                           in_falling_edge,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [setg_pkg::INDEX_BITS-1:0] out_trigger_index,
  output logic                           out_found,
  input  logic                           cfg_wr_en,
  input  logic [setg_pkg::LEVEL_BITS-1:0] cfg_wr_data
);

  localparam int AW   = $clog2(STORE_DEPTH);
  localparam int SPAN = STORE_DEPTH / 2;
  localparam int HOFS = (SCREEN_WIDTH / 2) % STORE_DEPTH;
  localparam int CW   = (SAMPLE_BITS > setg_pkg::LEVEL_BITS) ? SAMPLE_BITS
                                                             : setg_pkg::LEVEL_BITS;
  localparam logic [AW-1:0] LAST     = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] HOFS_A   = AW'(HOFS);
  localparam logic [AW:0]   WRAP_ADD = (AW+1)'(STORE_DEPTH - HOFS);
  localparam logic [AW-1:0] SPAN_END = AW'(SPAN - 1);

  function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] p);
    dec_wrap = (p == '0) ? LAST : p - 1'b1;
  endfunction

  setg_pkg::state_t state_r, state_nxt;

  logic [setg_pkg::LEVEL_BITS-1:0] level_r;
  logic [AW-1:0]          newest_r;
  logic [AW-1:0]          start_r;
  logic [AW-1:0]          pos_r;
  logic [AW-1:0]          addr_r;
  logic [AW-1:0]          cnt_r;
  logic                   falling_r;
  logic [SAMPLE_BITS-1:0] cur_r;
  logic [AW-1:0]          res_pos_r;
  logic                   res_found_r;
  logic                   out_valid_r;
  logic [setg_pkg::INDEX_BITS-1:0] out_index_r;
  logic                   out_found_r;

  logic                   in_acc;
  logic                   store_acc;
  logic                   search_acc;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          rd_addr;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]          start_calc;
  logic [AW:0]            start_wrap;
  logic [CW-1:0]          cur_x, prev_x, lvl_x;
  logic                   cur_hi, prev_hi, hit;
  logic                   last_step;
  logic                   slot_free;
  logic [AW+10:0]         idx_ext;

  assign in_ready   = (state_r == setg_pkg::S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign store_acc  = in_acc && (in_func == setg_pkg::FUNC_STORE);
  assign search_acc = in_acc && (in_func == setg_pkg::FUNC_SEARCH);

  assign wr_addr    = (newest_r == LAST) ? '0 : newest_r + 1'b1;
  assign start_wrap = {1'b0, newest_r} + WRAP_ADD;
  assign start_calc = (newest_r >= HOFS_A) ? newest_r - HOFS_A : start_wrap[AW-1:0];

  // shared compare: cur_r holds store[pos], rd_data is store[pos-1]
  assign cur_x   = CW'(cur_r);
  assign prev_x  = CW'(rd_data);
  assign lvl_x   = CW'(level_r);
  assign cur_hi  = (cur_x >= lvl_x);
  assign prev_hi = (prev_x >= lvl_x);
  assign hit     = falling_r ? (!cur_hi && prev_hi) : (cur_hi && !prev_hi);

  assign last_step = (cnt_r == SPAN_END);
  assign slot_free = !out_valid_r || out_ready;
  assign idx_ext   = {11'b0, res_pos_r};

  always_comb begin
    state_nxt = state_r;
    rd_addr   = addr_r;
    unique case (state_r)
      setg_pkg::S_IDLE: begin
        rd_addr = start_calc;
        if (search_acc) begin
          state_nxt = setg_pkg::S_FIRST;
        end
      end
      setg_pkg::S_FIRST: begin
        rd_addr   = dec_wrap(pos_r);
        state_nxt = setg_pkg::S_SCAN;
      end
      setg_pkg::S_SCAN: begin
        rd_addr = dec_wrap(addr_r);
        if (hit || last_step) begin
          state_nxt = setg_pkg::S_DONE;
        end
      end
      setg_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = setg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = setg_pkg::S_IDLE;
      end
    endcase
  end

  setg_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .DW    (SAMPLE_BITS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (store_acc),
    .wr_addr (wr_addr),
    .wr_data (in_sample_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= setg_pkg::S_IDLE;
      level_r     <= setg_pkg::LEVEL_RESET;
      newest_r    <= LAST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        level_r <= cfg_wr_data;
      end
      if (store_acc) begin
        newest_r <= wr_addr;
      end
      if (state_r == setg_pkg::S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      setg_pkg::S_IDLE: begin
        if (search_acc) begin
          start_r   <= start_calc;
          pos_r     <= start_calc;
          falling_r <= in_falling_edge;
          cnt_r     <= '0;
        end
      end
      setg_pkg::S_FIRST: begin
        cur_r  <= rd_data;
        addr_r <= rd_addr;
      end
      setg_pkg::S_SCAN: begin
        if (hit) begin
          res_pos_r   <= pos_r;
          res_found_r <= 1'b1;
        end else if (last_step) begin
          res_pos_r   <= start_r;
          res_found_r <= 1'b0;
        end else begin
          cur_r  <= rd_data;
          pos_r  <= addr_r;
          addr_r <= rd_addr;
          cnt_r  <= cnt_r + 1'b1;
        end
      end
      setg_pkg::S_DONE: begin
        if (slot_free) begin
          out_index_r <= idx_ext[10:0];
          out_found_r <= res_found_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_index = out_index_r;
  assign out_found         = out_found_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("state register not one-hot");

  a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
    search_acc |=> state_r == setg_pkg::S_FIRST)
    else $error("search item did not start the scan");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == setg_pkg::S_SCAN |-> cnt_r <= SPAN_END)
    else $error("scan ran past half the store");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == setg_pkg::S_DONE))
    else $error("output item raised outside the done state");

  a_miss_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == setg_pkg::S_DONE && !res_found_r |-> res_pos_r == start_r)
    else $error("missed search does not report the start index");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the scope edge trigger search block. Stores and searches go
// in over a valid/ready channel with random gaps. Trigger results come back
// with random stalls. Each result is checked against a cycle-free model of the
// sample store and of the backward crossing search. The trigger level is
// changed between phases, and the extremes 0 and 4095 are among the levels.
// ----------------------------------------------------------------------------
module tb;

  localparam int STORE_DEPTH  = 2048;
  localparam int SCREEN_WIDTH = 128;
  localparam int SAMPLE_BITS  = 12;
  localparam int INDEX_BITS   = setg_pkg::INDEX_BITS;
  localparam int LEVEL_BITS   = setg_pkg::LEVEL_BITS;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 1100;

  typedef struct packed {
    logic [INDEX_BITS-1:0] trig_pos;
    logic                  hit;
  } trig_result_t;

  logic                   clk             = 1'b0;
  logic                   rst_n           = 1'b0;
  logic                   in_valid        = 1'b0;
  logic                   in_ready;
  logic                   in_func         = setg_pkg::FUNC_STORE;
  logic [SAMPLE_BITS-1:0] in_sample_value = '0;
  logic                   in_falling_edge = 1'b0;
  logic                   out_valid;
  logic                   out_ready       = 1'b0;
  logic [INDEX_BITS-1:0]  out_trigger_index;
  logic                   out_found;
  logic                   cfg_wr_en       = 1'b0;
  logic [LEVEL_BITS-1:0]  cfg_wr_data     = '0;

  // model state
  logic [SAMPLE_BITS-1:0] sample_mem [STORE_DEPTH];
  logic [INDEX_BITS-1:0]  newest_idx;
  logic [LEVEL_BITS-1:0]  level_reg;
  trig_result_t           trig_expected [$];
  trig_result_t           head_trig;

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int hits_seen    = 0;
  int level_writes = 0;
  int quiet_cycles = 0;

  scope_edge_trigger_search #(
    .STORE_DEPTH (STORE_DEPTH),
    .SCREEN_WIDTH(SCREEN_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_sample_value  (in_sample_value),
    .in_falling_edge  (in_falling_edge),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_trigger_index(out_trigger_index),
    .out_found        (out_found),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void reset_model();
    for (int i = 0; i < STORE_DEPTH; i++) sample_mem[i] = '0;
    newest_idx = INDEX_BITS'(STORE_DEPTH - 1);
    level_reg  = setg_pkg::LEVEL_RESET;
  endfunction

  // walk back from half a screen before the newest sample
  function automatic trig_result_t search_trigger(input logic falling);
    trig_result_t           r;
    logic [INDEX_BITS-1:0]  start_pos;
    logic [INDEX_BITS-1:0]  pos;
    logic [SAMPLE_BITS-1:0] cur;
    logic [SAMPLE_BITS-1:0] prv;
    logic                   crossed;
    start_pos  = newest_idx - INDEX_BITS'(SCREEN_WIDTH / 2);
    pos        = start_pos;
    r.trig_pos = start_pos;
    r.hit      = 1'b0;
    for (int k = 0; k < STORE_DEPTH / 2; k++) begin
      cur = sample_mem[pos];
      prv = sample_mem[pos - 1'b1];
      crossed = falling ? (cur < level_reg && prv >= level_reg)
                        : (cur >= level_reg && prv < level_reg);
      if (crossed) begin
        r.trig_pos = pos;
        r.hit      = 1'b1;
        break;
      end
      pos = pos - 1'b1;
    end
    return r;
  endfunction

  // sample on one side of the current level, often right at it
  function automatic logic [SAMPLE_BITS-1:0] level_side(input bit above);
    int lv;
    lv = level_reg;
    if (above || lv == 0) begin
      if ($urandom_range(0, 3) == 0) return SAMPLE_BITS'(lv);
      return SAMPLE_BITS'($urandom_range(4095, lv));
    end
    if ($urandom_range(0, 3) == 0) return SAMPLE_BITS'(lv - 1);
    return SAMPLE_BITS'($urandom_range(lv - 1, 0));
  endfunction

  task automatic send_item(input logic func, input logic [SAMPLE_BITS-1:0] sample,
                           input logic falling);
    if (in_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_sample_value <= sample;
    in_falling_edge <= falling;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (func == setg_pkg::FUNC_STORE) begin
      newest_idx = newest_idx + 1'b1;
      sample_mem[newest_idx] = sample;
    end else begin
      trig_expected.push_back(search_trigger(falling));
    end
  endtask

  task automatic set_level(input logic [LEVEL_BITS-1:0] value);
    in_valid <= 1'b0;
    while (trig_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    level_reg = value;
    level_writes++;
  endtask

  // searches over the cleared store
  task automatic test_empty_search();
    send_item(setg_pkg::FUNC_SEARCH, 12'hfff, 1'b0);
    send_item(setg_pkg::FUNC_SEARCH, 12'h000, 1'b1);
  endtask

  // a rising crossing at index 0 lands on the last examined position, then
  // one more sample pushes it out of the span
  task automatic test_span_limit();
    send_item(setg_pkg::FUNC_STORE, 12'hfff, 1'b1);
    send_item(setg_pkg::FUNC_STORE, SAMPLE_BITS'(setg_pkg::LEVEL_RESET), 1'b0);
    for (int i = 2; i < STORE_DEPTH / 2 + SCREEN_WIDTH / 2; i++)
      send_item(setg_pkg::FUNC_STORE, level_side(1'b1), 1'($urandom));
    send_item(setg_pkg::FUNC_SEARCH, 12'($urandom), 1'b0);
    send_item(setg_pkg::FUNC_SEARCH, 12'($urandom), 1'b1);
    send_item(setg_pkg::FUNC_STORE, level_side(1'b1), 1'($urandom));
    send_item(setg_pkg::FUNC_SEARCH, 12'($urandom), 1'b0);
  endtask

  // rising crossing at the start position, falling one just before it, extreme levels
  task automatic test_slopes();
    set_level(12'd1000);
    send_item(setg_pkg::FUNC_STORE, 12'h000, 1'b0);
    send_item(setg_pkg::FUNC_STORE, 12'hfff, 1'b1);
    for (int i = 0; i < SCREEN_WIDTH / 2; i++)
      send_item(setg_pkg::FUNC_STORE, 12'hfff, 1'b0);
    send_item(setg_pkg::FUNC_SEARCH, 12'h000, 1'b0);
    send_item(setg_pkg::FUNC_SEARCH, 12'hfff, 1'b1);
    set_level(12'd4095);
    send_item(setg_pkg::FUNC_SEARCH, 12'h555, 1'b0);
    send_item(setg_pkg::FUNC_SEARCH, 12'haaa, 1'b1);
    set_level(12'd0);
    send_item(setg_pkg::FUNC_SEARCH, 12'h000, 1'b0);
    send_item(setg_pkg::FUNC_SEARCH, 12'h000, 1'b1);
  endtask

  task automatic test_random();
    logic [LEVEL_BITS-1:0] levels [6];
    int  count;
    int  n;
    int  half;
    int  pick;
    bit  above;
    levels[0] = 12'd2048;
    levels[1] = 12'd0;
    levels[2] = 12'd4095;
    levels[3] = 12'd1;
    levels[4] = 12'($urandom);
    levels[5] = 12'($urandom_range(4094, 1));
    for (int ph = 0; ph < 6; ph++) begin
      set_level(levels[ph]);
      count = 0;
      while (count < 60) begin
        if (ph == 5 && count >= 30) begin
          in_idle_on  = 1'b0;
          out_idle_on = 1'b0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // square-ish wave around the level, then search
          n     = $urandom_range(1, 150);
          half  = $urandom_range(1, 40);
          above = 1'($urandom);
          for (int i = 0; i < n; i++) begin
            if (i > 0 && i % half == 0) above = !above;
            if ($urandom_range(0, 19) == 0)
              send_item(setg_pkg::FUNC_STORE, 12'($urandom), 1'($urandom));
            else
              send_item(setg_pkg::FUNC_STORE, level_side(above), 1'($urandom));
          end
          count += n;
          repeat ($urandom_range(1, 2)) begin
            send_item(setg_pkg::FUNC_SEARCH, 12'($urandom), 1'($urandom));
            count++;
          end
        end else if (pick < 85) begin
          n = $urandom_range(1, 60);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 14) == 0)
              send_item(setg_pkg::FUNC_SEARCH, 12'($urandom), 1'($urandom));
            else
              send_item(setg_pkg::FUNC_STORE, 12'($urandom), 1'($urandom));
          end
          count += n;
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(setg_pkg::FUNC_SEARCH, 12'($urandom), 1'($urandom));
          count += n;
        end
      end
    end
  endtask

  task automatic finish_run();
    in_valid <= 1'b0;
    while (trig_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (trig_expected.size() != 0) begin
      $display("%0t: %0d trigger results never arrived", $time, trig_expected.size());
      errors++;
    end
    $display("Sent %0d items; checked %0d trigger searches, %0d of them with a crossing.",
             items_sent, results_seen, hits_seen);
    $display("Level written %0d times, including 0 and 4095; %0d mismatches.",
             level_writes, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_search();
    test_span_limit();
    test_slopes();
    test_random();
    finish_run();
  end

  // result side stalls
  initial begin
    @(posedge clk);
    forever begin
      if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (trig_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, got index %0d found %0b",
                 $time, out_trigger_index, out_found);
        errors++;
      end else begin
        head_trig = trig_expected.pop_front();
        results_seen++;
        if (head_trig.hit) hits_seen++;
        if (out_trigger_index !== head_trig.trig_pos) begin
          $display("%0t: trigger_index mismatch, expected %0d, got %0d",
                   $time, head_trig.trig_pos, out_trigger_index);
          errors++;
        end
        if (out_found !== head_trig.hit) begin
          $display("%0t: found mismatch, expected %0b, got %0b",
                   $time, head_trig.hit, out_found);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule

// ===== scope_edge_trigger_search.f =====
rtl/setg_pkg.sv
rtl/setg_store.sv
rtl/scope_edge_trigger_search.sv
sim/tb.sv
